/* hdl/isr_pkg.sv */
package isr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int RADICAND_WIDTH = 32;
    localparam int ROOT_WIDTH     = 16;
    localparam int SEARCH_MAX     = 32;

    typedef struct packed {
        logic load;
        logic square;
        logic step;
        logic emit;
    } isr_cmd_t;

    typedef struct packed {
        logic neg;
        logic hit;
        logic cont;
    } isr_sts_t;

endpackage

/* hdl/isr_in_if.sv */
interface isr_in_if;

    logic                                       valid;
    logic                                       ready;
    logic signed [isr_pkg::RADICAND_WIDTH-1:0]  radicand;

    modport source (output valid, output radicand, input ready);
    modport sink (input valid, input radicand, output ready);

endinterface

/* hdl/isr_out_if.sv */
interface isr_out_if;

    logic                           valid;
    logic                           ready;
    logic [isr_pkg::ROOT_WIDTH-1:0] root;
    logic                           negative_input;
    logic                           exact;

    modport source (output valid, output root, output negative_input, output exact, input ready);
    modport sink (input valid, input root, input negative_input, input exact, output ready);

endinterface

/* hdl/isr_datapath.sv */
module isr_datapath #(
    parameter int DATA_WIDTH = isr_pkg::DATA_WIDTH_DEF
) (
    input  logic                                       clk,
    input  isr_pkg::isr_cmd_t                          cmd,
    input  logic signed [isr_pkg::RADICAND_WIDTH-1:0]  radicand,
    output isr_pkg::isr_sts_t                          sts,
    output logic [isr_pkg::ROOT_WIDTH-1:0]             root,
    output logic                                       negative_input,
    output logic                                       exact
);

    localparam int SW = (DATA_WIDTH > isr_pkg::SEARCH_MAX) ? isr_pkg::SEARCH_MAX : DATA_WIDTH;
    localparam int CW = 2 * SW;
    localparam logic [SW-1:0] HI_CAP = {SW{1'b1}};

    logic [DATA_WIDTH-1:0] n_in;
    logic [CW-1:0]         n_ext;
    logic [SW-1:0]         hi_init;

    logic [CW-1:0] n_reg;
    logic [CW-1:0] sq_reg;
    logic [CW-1:0] sq_next;
    logic [SW-1:0] lo_reg;
    logic [SW-1:0] hi_reg;
    logic [SW-1:0] mid_reg;
    logic [SW-1:0] best_reg;
    logic          exact_reg;
    logic          neg_reg;

    logic [isr_pkg::ROOT_WIDTH-1:0] root_reg;
    logic                           neg_out_reg;
    logic                           exact_out_reg;

    logic          hit;
    logic          above;
    logic          cont_low;
    logic          cont_high;
    logic [SW:0]   sum_low;
    logic [SW:0]   sum_high;
    logic [SW-1:0] mid_dec;
    logic [SW-1:0] mid_inc;

    assign n_in    = DATA_WIDTH'(radicand);
    assign n_ext   = CW'(n_in);
    assign hi_init = (n_ext > CW'(HI_CAP)) ? HI_CAP : n_ext[SW-1:0];

    assign sq_next = mid_reg * mid_reg;

    assign hit       = (sq_reg == n_reg);
    assign above     = (sq_reg > n_reg);
    assign mid_dec   = mid_reg - SW'(1);
    assign mid_inc   = mid_reg + SW'(1);
    assign cont_low  = (lo_reg < mid_reg);
    assign cont_high = (mid_reg < hi_reg);
    assign sum_low   = {1'b0, lo_reg} + {1'b0, mid_dec};
    assign sum_high  = {1'b0, mid_inc} + {1'b0, hi_reg};

    assign sts.neg  = neg_reg;
    assign sts.hit  = hit;
    assign sts.cont = above ? cont_low : cont_high;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg     <= n_ext;
            neg_reg   <= n_in[DATA_WIDTH-1];
            lo_reg    <= '0;
            hi_reg    <= hi_init;
            mid_reg   <= hi_init >> 1;
            best_reg  <= '0;
            exact_reg <= 1'b0;
        end
        if (cmd.square)
        begin
            sq_reg <= sq_next;
        end
        if (cmd.step)
        begin
            priority if (hit)
            begin
                best_reg  <= mid_reg;
                exact_reg <= 1'b1;
            end
            else if (above)
            begin
                hi_reg  <= mid_dec;
                mid_reg <= sum_low[SW:1];
            end
            else
            begin
                best_reg <= mid_reg;
                lo_reg   <= mid_inc;
                mid_reg  <= sum_high[SW:1];
            end
        end
        if (cmd.emit)
        begin
            root_reg      <= isr_pkg::ROOT_WIDTH'(best_reg);
            neg_out_reg   <= neg_reg;
            exact_out_reg <= exact_reg;
        end
    end

    assign root           = root_reg;
    assign negative_input = neg_out_reg;
    assign exact          = exact_out_reg;

endmodule

/* hdl/isr_ctrl.sv */
module isr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  isr_pkg::isr_sts_t sts,
    output isr_pkg::isr_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SQUARE  = 4'b0010,
        S_COMPARE = 4'b0100,
        S_FINISH  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                if (sts.neg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.square = 1'b1;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd.step = 1'b1;
                if (sts.hit || !sts.cont)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SQUARE;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/integer_square_root_unit.sv */
// Integer square root unit.
// operand (sink): one signed radicand per item, taken while the unit is idle.
// result (source): one item per operand: root = floor(sqrt(radicand)),
//   exact when root * root equals the radicand, negative_input for a negative
//   radicand (root 0, exact 0).
// Sequence: the accepting edge loads the search, then a binary search over
//   [0, radicand] runs step by step: square the midpoint in S_SQUARE, then
//   compare and narrow the interval in S_COMPARE; S_FINISH then moves the
//   result into the output register once it is free. The search ends early on
//   an exact square. A negative radicand skips the search and goes from
//   S_SQUARE straight to S_FINISH. The single shared multiplier and the
//   compare-to-compare dependence of the search keep the steps serial.
// Throughput: one item at a time; the next operand is taken in the cycle
//   after the current result has moved into the output register.
// Stall: a result waits in the output register while result.ready is low; a
//   finished search holds until that register frees, and operand.ready stays
//   low meanwhile.
// Reset: rst_n clears the controller to idle and drops result.valid.
module integer_square_root_unit #(
    parameter int DATA_WIDTH = isr_pkg::DATA_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    isr_in_if.sink   operand,
    isr_out_if.source result
);

    isr_pkg::isr_cmd_t cmd;
    isr_pkg::isr_sts_t sts;

    isr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand.valid),
        .in_ready  (operand.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    isr_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .cmd            (cmd),
        .radicand       (operand.radicand),
        .sts            (sts),
        .root           (result.root),
        .negative_input (result.negative_input),
        .exact          (result.exact)
    );

endmodule
